FILE: hw/rtl/ntpsrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ntpsrl_pkg;

  // Table geometry.
  localparam int RATE_ENTRIES = 1024;
  localparam int RATE_WAYS    = 4;
  localparam int MAC_ENTRIES  = 16;

  localparam int NSETS = ((RATE_ENTRIES / RATE_WAYS) > 0) ? (RATE_ENTRIES / RATE_WAYS) : 1;
  localparam int SET_W = (NSETS > 1) ? $clog2(NSETS) : 1;
  localparam int WAY_W = (RATE_WAYS > 1) ? $clog2(RATE_WAYS) : 1;
  localparam int MAC_W = (MAC_ENTRIES > 1) ? $clog2(MAC_ENTRIES) : 1;

  // Header constants.
  localparam logic [15:0] ETH_LEN     = 16'd14;
  localparam logic [15:0] ETH_IP_LEN  = 16'd34;
  localparam logic [15:0] TCP_LEN     = 16'd20;
  localparam logic [15:0] UDP_LEN     = 16'd8;
  localparam logic [15:0] TYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // Register reset values.
  localparam logic [15:0] WINDOW_RST  = 16'd1000;
  localparam logic [15:0] LIMIT_RST   = 16'd50;
  localparam logic [15:0] SSH_RST     = 16'd22;
  localparam logic [15:0] NTP_RST     = 16'd123;
  localparam logic [15:0] IFACE_A_RST = 16'd3;
  localparam logic [15:0] IFACE_B_RST = 16'd4;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_MAC_SET  = 2'd1,
    OP_MAC_DEL  = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    V_DROP       = 2'd0,
    V_PASS       = 2'd1,
    V_REDIRECT   = 2'd2,
    V_TABLE_DONE = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    CFG_WINDOW  = 3'd0,
    CFG_LIMIT   = 3'd1,
    CFG_SSH     = 3'd2,
    CFG_NTP     = 3'd3,
    CFG_IFACE_A = 3'd4,
    CFG_IFACE_B = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_header_words;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] source_addr;
    logic [15:0] ingress_iface;
    logic [47:0] now_ms;
    logic [47:0] mac_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] out_iface;
    logic        rewrite_mac;
    logic [47:0] new_dest_mac;
    logic        table_full;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] source;
    logic [47:0] start;
    logic [15:0] count;
  } rate_way_t;

  typedef logic [RATE_WAYS-1:0][WAY_W-1:0] lru_t;

  typedef struct packed {
    rate_way_t [RATE_WAYS-1:0] way;
    lru_t                      lru;
  } rate_row_t;

  typedef struct packed {
    logic clr;
    logic load_item;
    logic exec;
    logic look;
    logic upd;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_rate;
    logic clr_last;
  } dp_sts_t;

  function automatic lru_t lru_init();
    lru_t l;
    for (int w = 0; w < RATE_WAYS; w++) begin
      l[w] = WAY_W'(w);
    end
    return l;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ntpsrl_intf.sv
`timescale 1ns / 1ps
`default_nettype none
interface ntpsrl_in_if;
  logic                valid;
  logic                ready;
  ntpsrl_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ntpsrl_out_if;
  logic                 valid;
  logic                 ready;
  ntpsrl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ntpsrl_cfg_if;
  logic                valid;
  logic                ready;
  ntpsrl_pkg::cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ntpsrl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ntpsrl_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  input  wire ntpsrl_pkg::dp_sts_t   sts_i,
  output ntpsrl_pkg::ctrl_cmd_t      cmd_o
);
  import ntpsrl_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_UPDATE,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.clr       = (state_q == S_CLEAR);
    cmd_o.load_item = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.look      = (state_q == S_LOOK);
    cmd_o.upd       = (state_q == S_UPDATE);
    cmd_o.load_out  = (state_q == S_DONE) && out_free;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= sts_i.need_rate ? S_LOOK : S_DONE;
        end
        S_LOOK: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a waiting result");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> (state_q == S_EXEC))
    else $error("accepted request not executed");
  a_update_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> ($past(state_q) == S_LOOK))
    else $error("rate update without lookup");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/ntpsrl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ntpsrl_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ntpsrl_pkg::ctrl_cmd_t cmd_i,
  output ntpsrl_pkg::dp_sts_t        sts_o,
  input  wire ntpsrl_pkg::in_item_t  item_i,
  input  wire logic                  cfg_we_i,
  input  wire ntpsrl_pkg::cfg_req_t  cfg_i,
  output ntpsrl_pkg::out_item_t      out_o
);
  import ntpsrl_pkg::*;

  logic [15:0] window_q, limit_q, ssh_q, ntp_q, iface_a_q, iface_b_q;
  in_item_t    item_q;
  out_item_t   res_q, res_d, out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_RST;
      limit_q   <= LIMIT_RST;
      ssh_q     <= SSH_RST;
      ntp_q     <= NTP_RST;
      iface_a_q <= IFACE_A_RST;
      iface_b_q <= IFACE_B_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_i.index))
        CFG_WINDOW:  window_q  <= cfg_i.value;
        CFG_LIMIT:   limit_q   <= cfg_i.value;
        CFG_SSH:     ssh_q     <= cfg_i.value;
        CFG_NTP:     ntp_q     <= cfg_i.value;
        CFG_IFACE_A: iface_a_q <= cfg_i.value;
        CFG_IFACE_B: iface_b_q <= cfg_i.value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  // MAC table in flip-flops.
  logic [MAC_ENTRIES-1:0] mac_valid_q;
  logic [15:0]            mac_iface_q [MAC_ENTRIES];
  logic [47:0]            mac_addr_q  [MAC_ENTRIES];
  logic [15:0]            tgt;
  logic [MAC_ENTRIES-1:0] hit_a, hit_t;
  logic [MAC_W-1:0]       idx_a, idx_t, idx_free;
  logic                   any_a, any_t, any_free;

  assign tgt = (item_q.ingress_iface == iface_a_q) ? iface_b_q : iface_a_q;

  always_comb begin
    idx_a    = '0;
    idx_t    = '0;
    idx_free = '0;
    for (int i = 0; i < MAC_ENTRIES; i++) begin
      hit_a[i] = mac_valid_q[i] && (mac_iface_q[i] == item_q.ingress_iface);
      hit_t[i] = mac_valid_q[i] && (mac_iface_q[i] == tgt);
    end
    for (int i = MAC_ENTRIES - 1; i >= 0; i--) begin
      if (hit_a[i]) idx_a = MAC_W'(i);
      if (hit_t[i]) idx_t = MAC_W'(i);
      if (!mac_valid_q[i]) idx_free = MAC_W'(i);
    end
    any_a    = |hit_a;
    any_t    = |hit_t;
    any_free = !(&mac_valid_q);
  end

  // Header checks.
  logic [15:0] l4_len;
  logic        hdr_ok, tcp_ok, icmp_ok, udp_ntp;

  assign l4_len  = ETH_LEN + {10'd0, item_q.ip_header_words, 2'b00};
  assign hdr_ok  = (item_q.frame_len >= ETH_LEN) && (item_q.ether_type == TYPE_IPV4)
                   && (item_q.frame_len >= ETH_IP_LEN);
  assign tcp_ok  = hdr_ok && (item_q.ip_protocol == PROTO_TCP)
                   && ((l4_len + TCP_LEN) <= item_q.frame_len)
                   && ((item_q.dest_port == ssh_q) || (item_q.source_port == ssh_q));
  assign icmp_ok = hdr_ok && (item_q.ip_protocol == PROTO_ICMP);
  assign udp_ntp = hdr_ok && (item_q.ip_protocol == PROTO_UDP)
                   && ((l4_len + UDP_LEN) <= item_q.frame_len)
                   && ((item_q.dest_port == ntp_q) || (item_q.source_port == ntp_q));

  assign sts_o.need_rate = (opcode_e'(item_q.opcode) == OP_CLASSIFY) && udp_ntp;

  logic             mac_we, mac_clr;
  logic [MAC_W-1:0] mac_widx;

  // Rate table: one row per set, read-modify-write through one port.
  rate_row_t        rate_mem [NSETS];
  rate_row_t        row_q, row_d, clr_row;
  logic [SET_W-1:0] clr_q, rd_set, mem_addr;
  logic             mem_we;
  logic [WAY_W-1:0] sel_q, sel_d, pos;
  logic             hit_q, hit_d, free_d;
  logic [WAY_W-1:0] hit_way, free_way;
  rate_way_t        cur, nway;
  logic [47:0]      age;
  logic             in_win, allowed;
  logic [15:0]      cnt;

  assign rd_set = SET_W'(item_q.source_addr % NSETS);
  assign sts_o.clr_last = (clr_q == SET_W'(NSETS - 1));

  always_comb begin
    clr_row     = '0;
    clr_row.lru = lru_init();
  end

  assign mem_we   = cmd_i.clr || cmd_i.upd;
  assign mem_addr = cmd_i.clr ? clr_q : rd_set;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rate_mem[mem_addr] <= cmd_i.clr ? clr_row : row_d;
    end
    if (cmd_i.exec) begin
      row_q <= rate_mem[rd_set];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + SET_W'(1);
    end
  end

  // Way lookup.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    hit_d    = 1'b0;
    free_d   = 1'b0;
    for (int w = RATE_WAYS - 1; w >= 0; w--) begin
      if (row_q.way[w].valid && (row_q.way[w].source == item_q.source_addr)) begin
        hit_way = WAY_W'(w);
        hit_d   = 1'b1;
      end
      if (!row_q.way[w].valid) begin
        free_way = WAY_W'(w);
        free_d   = 1'b1;
      end
    end
    sel_d = hit_d ? hit_way : (free_d ? free_way : row_q.lru[0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      sel_q <= sel_d;
      hit_q <= hit_d;
    end
  end

  // Window update and LRU touch.
  always_comb begin
    cur     = row_q.way[sel_q];
    age     = item_q.now_ms - cur.start;
    in_win  = age < {32'd0, window_q};
    cnt     = (cur.count == COUNT_MAX) ? cur.count : (cur.count + 16'd1);
    allowed = 1'b1;
    if (hit_q && in_win) begin
      nway       = cur;
      nway.count = cnt;
      allowed    = (cnt <= limit_q);
    end else begin
      nway.valid  = 1'b1;
      nway.source = item_q.source_addr;
      nway.start  = item_q.now_ms;
      nway.count  = 16'd1;
    end
    pos = WAY_W'(RATE_WAYS - 1);
    for (int p = RATE_WAYS - 1; p >= 0; p--) begin
      if (row_q.lru[p] == sel_q) pos = WAY_W'(p);
    end
    row_d            = row_q;
    row_d.way[sel_q] = nway;
    for (int p = 0; p < RATE_WAYS - 1; p++) begin
      if (WAY_W'(p) >= pos) row_d.lru[p] = row_q.lru[p+1];
    end
    row_d.lru[RATE_WAYS-1] = sel_q;
  end

  // Result selection and MAC commands.
  always_comb begin
    res_d    = '0;
    mac_we   = 1'b0;
    mac_clr  = 1'b0;
    mac_widx = idx_a;
    if (cmd_i.upd) begin
      if (allowed) begin
        res_d.verdict      = V_REDIRECT;
        res_d.out_iface    = tgt;
        res_d.rewrite_mac  = any_t;
        res_d.new_dest_mac = any_t ? mac_addr_q[idx_t] : 48'd0;
      end
    end else begin
      unique case (opcode_e'(item_q.opcode))
        OP_MAC_SET: begin
          res_d.verdict = V_TABLE_DONE;
          if (any_a) begin
            mac_we = cmd_i.exec;
          end else if (any_free) begin
            mac_we   = cmd_i.exec;
            mac_widx = idx_free;
          end else begin
            res_d.table_full = 1'b1;
          end
        end
        OP_MAC_DEL: begin
          res_d.verdict = V_TABLE_DONE;
          mac_clr       = cmd_i.exec && any_a;
        end
        OP_CLASSIFY: begin
          if (tcp_ok) begin
            res_d.verdict = V_PASS;
          end else if (icmp_ok) begin
            res_d.verdict      = V_PASS;
            res_d.rewrite_mac  = any_a;
            res_d.new_dest_mac = any_a ? mac_addr_q[idx_a] : 48'd0;
          end
        end
        OP_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_valid_q <= '0;
    end else if (mac_we) begin
      mac_valid_q[mac_widx] <= 1'b1;
    end else if (mac_clr) begin
      mac_valid_q[idx_a] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_we) begin
      mac_iface_q[mac_widx] <= item_q.ingress_iface;
      mac_addr_q[mac_widx]  <= item_q.mac_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec || cmd_i.upd) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ntp_source_rate_limit_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// After a request is accepted it runs the execute state and, for rate-limited UDP, the lookup and
// update states; its result is shown once the done state finds the output register free. A new
// request is accepted only after that; the single-port rate table memory is read, modified and written.
// Reset: asynchronous, active low; afterwards a clearing pass over every rate table set runs before
// the first request is accepted.
module ntp_source_rate_limit_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ntpsrl_in_if.sink        in_i,
  ntpsrl_out_if.source     out_o,
  ntpsrl_cfg_if.sink       cfg_i
);
  import ntpsrl_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;
  logic      out_valid;

  // Registers are always writable; the user writes them only while the block is idle.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // The controller sequences each request: execute, then, for NTP traffic, look up the
  // set and write back the updated row before the result is passed to the output
  // register. A new request may be accepted while an earlier result is still waiting.
  ntpsrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, the MAC table and the set-associative rate table.
  ntpsrl_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .item_i   (in_i.data),
    .cfg_we_i (cfg_i.valid),
    .cfg_i    (cfg_i.data),
    .out_o    (out_o.data)
  );

endmodule
`default_nettype wire
